### design/buffer_pool_page_replacement_defines.svh
// Assertion macros for the buffer pool frame table.
`ifndef BUFFER_POOL_PAGE_REPLACEMENT_DEFINES_SVH
`define BUFFER_POOL_PAGE_REPLACEMENT_DEFINES_SVH

`ifndef SYNTHESIS
`define BPPR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define BPPR_ASSERT_NEVER(lbl, cond, msg) \
  `BPPR_ASSERT(lbl, !(cond), msg)
`else
`define BPPR_ASSERT(lbl, prop, msg)
`define BPPR_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

### design/bppr_pkg.sv
`timescale 1ns / 1ps
package bppr_pkg;

  localparam int NUM_FRAMES = 16;
  localparam int FRAME_BITS = 4;
  localparam int NFR_BITS   = 5;
  localparam int PAGE_BITS  = 24;
  localparam int PIN_BITS   = 8;
  localparam int CNT_BITS   = 16;

  localparam logic [1:0] REQ_PIN   = 2'd0;
  localparam logic [1:0] REQ_UNPIN = 2'd1;
  localparam logic [1:0] REQ_DIRTY = 2'd2;
  localparam logic [1:0] REQ_NONE  = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOFREE = 2'd1;
  localparam logic [1:0] ST_ABSENT = 2'd2;

  localparam logic [1:0] IO_NONE  = 2'd0;
  localparam logic [1:0] IO_WB    = 2'd1;
  localparam logic [1:0] IO_READ  = 2'd2;

  localparam logic [1:0] POL_FIFO  = 2'd0;
  localparam logic [1:0] POL_LRU   = 2'd1;
  localparam logic [1:0] POL_CLOCK = 2'd2;
  localparam logic [1:0] POL_RSVD  = 2'd3;

  localparam logic CFG_POLICY = 1'b0;
  localparam logic CFG_FRAMES = 1'b1;

  typedef struct packed {
    logic [PAGE_BITS-1:0] tag;
    logic                 dirty;
    logic [PIN_BITS-1:0]  pin;
  } frame_word_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [FRAME_BITS-1:0] frame;
    logic [1:0]            op;
    logic [PAGE_BITS-1:0]  page;
    logic                  last;
  } res_t;

endpackage

### design/buffer_pool_page_replacement.sv
`timescale 1ns / 1ps
// Channel   | Ports                                         | Handshake
// ----------+-----------------------------------------------+------------------------------
// request   | req_type_i, page_num_i                        | start high, busy low
// result    | status_o .. last_o, write_count_o             | res_valid_o, one cycle
// config    | cfg_idx_i, cfg_data_i                         | cfg_we_i, no wait
//
// Every request but REQ_NONE scans the frames in use, one frame per cycle.
// An LRU hit or FIFO/LRU load adds a rank pass; a load adds the victim read, write-back
// word and memory update. CLOCK adds hand reduction and a sweep that checks each frame in
// use at most twice. busy stays high until the rank pass is done.
// Reset clears control state and the frame valid bits; no clearing pass is run.
`include "buffer_pool_page_replacement_defines.svh"

module buffer_pool_page_replacement (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      req_type_i,
  input  logic [bppr_pkg::PAGE_BITS-1:0]  page_num_i,
  input  logic                            cfg_we_i,
  input  logic                            cfg_idx_i,
  input  logic [bppr_pkg::NFR_BITS-1:0]   cfg_data_i,
  output logic                            res_valid_o,
  output logic [1:0]                      status_o,
  output logic [bppr_pkg::FRAME_BITS-1:0] frame_index_o,
  output logic [1:0]                      io_op_o,
  output logic [bppr_pkg::PAGE_BITS-1:0]  io_page_o,
  output logic [bppr_pkg::CNT_BITS-1:0]   read_count_o,
  output logic [bppr_pkg::CNT_BITS-1:0]   write_count_o,
  output logic                            last_o
);

  localparam int NF = bppr_pkg::NUM_FRAMES;
  localparam int FB = bppr_pkg::FRAME_BITS;
  localparam int NB = bppr_pkg::NFR_BITS;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SCAN   = 4'd1;
  localparam logic [3:0] S_DECIDE = 4'd2;
  localparam logic [3:0] S_HMOD   = 4'd3;
  localparam logic [3:0] S_SWEEP  = 4'd4;
  localparam logic [3:0] S_VRD    = 4'd5;
  localparam logic [3:0] S_VEV    = 4'd6;
  localparam logic [3:0] S_LOAD   = 4'd7;
  localparam logic [3:0] S_POS    = 4'd8;
  localparam logic [3:0] S_COMMIT = 4'd9;

  logic [3:0] state_q, state_d;

  logic [1:0]                     policy_q;
  logic [NB-1:0]                  frames_q;
  logic [1:0]                     req_q;
  logic [bppr_pkg::PAGE_BITS-1:0] page_q;
  logic [NB-1:0]                  n_q;
  logic [1:0]                     mode_q;
  logic [FB-1:0]                  cnt_q;
  logic [NB:0]                    steps_q;
  logic [FB-1:0]                  hm_q;
  logic [FB-1:0]                  hand_q;
  logic                           found_q;
  logic [FB-1:0]                  hit_q;
  logic [bppr_pkg::PIN_BITS-1:0]  hit_pin_q;
  logic                           hit_dirty_q;
  logic                           got_q;
  logic [FB-1:0]                  vic_q;
  logic [FB-1:0]                  vic_rank_q;
  logic [NF-1:0]                  free_q;
  logic [NF-1:0]                  ref_q;
  logic [NF-1:0]                  valid_q;
  logic [FB-1:0]                  rank_q [NF];
  logic [FB-1:0]                  pos_q  [NF];
  logic [bppr_pkg::CNT_BITS-1:0]  reads_q;
  logic [bppr_pkg::CNT_BITS-1:0]  writes_q;
  bppr_pkg::res_t                 res_q;
  logic                           res_valid_q;

  bppr_pkg::frame_word_t frame_mem_q [NF];
  bppr_pkg::frame_word_t rd_word_q;
  logic                  rd_ok_q;
  bppr_pkg::frame_word_t rd_word;

  logic                  mem_re;
  logic [FB-1:0]         mem_raddr;
  logic                  mem_we;
  logic [FB-1:0]         mem_waddr;
  bppr_pkg::frame_word_t mem_wdata;

  logic [NB-1:0] cnt_nxt;
  logic          scan_last;
  logic [NF-1:0] bef;
  logic [NB-1:0] pos_cnt;
  logic [NB-1:0] n_in;
  logic          sweep_hit;

  function automatic bppr_pkg::res_t mk_res(logic [1:0] st, logic [FB-1:0] fr,
                                            logic [1:0] op,
                                            logic [bppr_pkg::PAGE_BITS-1:0] pg,
                                            logic lst);
    bppr_pkg::res_t r;
    r.status = st;
    r.frame  = fr;
    r.op     = op;
    r.page   = pg;
    r.last   = lst;
    return r;
  endfunction

  assign busy      = (state_q != S_IDLE);
  assign rd_word   = rd_ok_q ? rd_word_q : '0;
  assign cnt_nxt   = {1'b0, cnt_q} + NB'(1);
  assign scan_last = (cnt_nxt == n_q);
  assign sweep_hit = free_q[cnt_q] && !ref_q[cnt_q];

  always_comb begin
    if (frames_q == '0) begin
      n_in = NB'(1);
    end else if (frames_q > NB'(NF)) begin
      n_in = NB'(NF);
    end else begin
      n_in = frames_q;
    end
  end

  // Position of frame cnt_q in queue order among frames in use.
  always_comb begin
    for (int h = 0; h < NF; h++) begin
      bef[h] = (NB'(h) < n_q) && (FB'(h) != cnt_q) &&
               ((rank_q[h] < rank_q[cnt_q]) ||
                ((rank_q[h] == rank_q[cnt_q]) && (FB'(h) < cnt_q)));
    end
    pos_cnt = NB'($countones(bef));
  end

  always_comb begin
    state_d   = state_q;
    mem_re    = 1'b0;
    mem_raddr = '0;
    mem_we    = 1'b0;
    mem_waddr = (state_q == S_LOAD) ? vic_q : hit_q;
    mem_wdata = '{tag: page_q, dirty: hit_dirty_q, pin: hit_pin_q};
    unique case (state_q)
      S_IDLE: begin
        if (start && req_type_i != bppr_pkg::REQ_NONE) begin
          mem_re  = 1'b1;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_last) begin
          state_d = S_DECIDE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = cnt_nxt[FB-1:0];
        end
      end
      S_DECIDE: begin
        state_d = S_IDLE;
        unique case (req_q)
          bppr_pkg::REQ_UNPIN: begin
            if (found_q && hit_pin_q != '0) begin
              mem_we        = 1'b1;
              mem_wdata.pin = hit_pin_q - bppr_pkg::PIN_BITS'(1);
            end
          end
          bppr_pkg::REQ_DIRTY: begin
            if (found_q) begin
              mem_we          = 1'b1;
              mem_wdata.dirty = 1'b1;
            end
          end
          default: begin
            if (found_q) begin
              mem_we = 1'b1;
              if (hit_pin_q != '1) begin
                mem_wdata.pin = hit_pin_q + bppr_pkg::PIN_BITS'(1);
              end
              if (mode_q == bppr_pkg::POL_LRU) begin
                state_d = S_POS;
              end
            end else if (mode_q == bppr_pkg::POL_CLOCK) begin
              state_d = S_HMOD;
            end else if (got_q) begin
              state_d = S_VRD;
            end
          end
        endcase
      end
      S_HMOD: begin
        if ({1'b0, hm_q} < n_q) begin
          state_d = S_SWEEP;
        end
      end
      S_SWEEP: begin
        if (sweep_hit) begin
          state_d = S_VRD;
        end else if (steps_q == {n_q, 1'b0} - (NB + 1)'(1)) begin
          state_d = S_IDLE;
        end
      end
      S_VRD: begin
        mem_re    = 1'b1;
        mem_raddr = vic_q;
        state_d   = S_VEV;
      end
      S_VEV: begin
        state_d = S_LOAD;
      end
      S_LOAD: begin
        mem_we    = 1'b1;
        mem_wdata = '{tag: page_q, dirty: 1'b0, pin: bppr_pkg::PIN_BITS'(1)};
        state_d   = (mode_q == bppr_pkg::POL_CLOCK) ? S_IDLE : S_POS;
      end
      S_POS: begin
        if (scan_last) begin
          state_d = S_COMMIT;
        end
      end
      S_COMMIT: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      frame_mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_word_q <= frame_mem_q[mem_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_POS) begin
      pos_q[cnt_q] <= pos_cnt[FB-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      policy_q    <= bppr_pkg::POL_FIFO;
      frames_q    <= NB'(NF);
      req_q       <= bppr_pkg::REQ_PIN;
      page_q      <= '0;
      n_q         <= NB'(NF);
      mode_q      <= bppr_pkg::POL_FIFO;
      cnt_q       <= '0;
      steps_q     <= '0;
      hm_q        <= '0;
      hand_q      <= '0;
      found_q     <= 1'b0;
      hit_q       <= '0;
      hit_pin_q   <= '0;
      hit_dirty_q <= 1'b0;
      got_q       <= 1'b0;
      vic_q       <= '0;
      vic_rank_q  <= '0;
      free_q      <= '0;
      ref_q       <= '0;
      valid_q     <= '0;
      reads_q     <= '0;
      writes_q    <= '0;
      res_q       <= '0;
      res_valid_q <= 1'b0;
      rd_ok_q     <= 1'b0;
      for (int i = 0; i < NF; i++) begin
        rank_q[i] <= FB'(i);
      end
    end else begin
      state_q     <= state_d;
      res_valid_q <= 1'b0;
      if (mem_re) begin
        rd_ok_q <= valid_q[mem_raddr];
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == bppr_pkg::CFG_POLICY) begin
          policy_q <= cfg_data_i[1:0];
        end else begin
          frames_q <= cfg_data_i;
        end
      end
      unique case (state_q)
        S_IDLE: begin
          if (start) begin
            req_q   <= req_type_i;
            page_q  <= page_num_i;
            n_q     <= n_in;
            mode_q  <= (policy_q == bppr_pkg::POL_RSVD) ? bppr_pkg::POL_FIFO : policy_q;
            cnt_q   <= '0;
            found_q <= 1'b0;
            got_q   <= 1'b0;
          end
        end
        S_SCAN: begin
          if (!found_q && valid_q[cnt_q] && rd_word.tag == page_q) begin
            found_q     <= 1'b1;
            hit_q       <= cnt_q;
            hit_pin_q   <= rd_word.pin;
            hit_dirty_q <= rd_word.dirty;
          end
          free_q[cnt_q] <= (rd_word.pin == '0);
          // scan runs in frame order and needs a strictly lower rank, so on a tie the lower frame wins
          if (rd_word.pin == '0 && (!got_q || rank_q[cnt_q] < vic_rank_q)) begin
            got_q      <= 1'b1;
            vic_q      <= cnt_q;
            vic_rank_q <= rank_q[cnt_q];
          end
          if (!scan_last) begin
            cnt_q <= cnt_nxt[FB-1:0];
          end
        end
        S_DECIDE: begin
          unique case (req_q)
            bppr_pkg::REQ_UNPIN, bppr_pkg::REQ_DIRTY: begin
              res_valid_q <= 1'b1;
              if (found_q && (req_q == bppr_pkg::REQ_DIRTY || hit_pin_q != '0)) begin
                res_q <= mk_res(bppr_pkg::ST_OK, hit_q, bppr_pkg::IO_NONE, '0, 1'b1);
              end else begin
                res_q <= mk_res(bppr_pkg::ST_ABSENT, '0, bppr_pkg::IO_NONE, '0, 1'b1);
              end
            end
            default: begin
              if (found_q) begin
                ref_q[hit_q] <= 1'b1;
                vic_q        <= hit_q;
                cnt_q        <= '0;
                res_valid_q  <= 1'b1;
                res_q <= mk_res(bppr_pkg::ST_OK, hit_q, bppr_pkg::IO_NONE, '0, 1'b1);
              end else if (mode_q == bppr_pkg::POL_CLOCK) begin
                hm_q <= hand_q;
              end else if (!got_q) begin
                res_valid_q <= 1'b1;
                res_q <= mk_res(bppr_pkg::ST_NOFREE, '0, bppr_pkg::IO_NONE, '0, 1'b1);
              end
            end
          endcase
        end
        S_HMOD: begin
          if ({1'b0, hm_q} >= n_q) begin
            hm_q <= hm_q - n_q[FB-1:0];
          end else begin
            cnt_q   <= (({1'b0, hm_q} + NB'(1)) == n_q) ? '0 : hm_q + FB'(1);
            steps_q <= '0;
          end
        end
        S_SWEEP: begin
          if (sweep_hit) begin
            vic_q <= cnt_q;
          end else begin
            if (free_q[cnt_q]) begin
              ref_q[cnt_q] <= 1'b0;
            end
            steps_q <= steps_q + (NB + 1)'(1);
            cnt_q   <= scan_last ? '0 : cnt_nxt[FB-1:0];
            if (steps_q == {n_q, 1'b0} - (NB + 1)'(1)) begin
              res_valid_q <= 1'b1;
              res_q <= mk_res(bppr_pkg::ST_NOFREE, '0, bppr_pkg::IO_NONE, '0, 1'b1);
            end
          end
        end
        S_VRD: begin
        end
        S_VEV: begin
          if (rd_word.dirty) begin
            if (writes_q != '1) begin
              writes_q <= writes_q + bppr_pkg::CNT_BITS'(1);
            end
            res_valid_q <= 1'b1;
            res_q <= mk_res(bppr_pkg::ST_OK, vic_q, bppr_pkg::IO_WB, rd_word.tag, 1'b0);
          end
        end
        S_LOAD: begin
          if (reads_q != '1) begin
            reads_q <= reads_q + bppr_pkg::CNT_BITS'(1);
          end
          valid_q[vic_q] <= 1'b1;
          ref_q[vic_q]   <= 1'b1;
          cnt_q          <= '0;
          if (mode_q == bppr_pkg::POL_CLOCK) begin
            hand_q <= vic_q;
          end
          res_valid_q <= 1'b1;
          res_q <= mk_res(bppr_pkg::ST_OK, vic_q, bppr_pkg::IO_READ, page_q, 1'b1);
        end
        S_POS: begin
          if (!scan_last) begin
            cnt_q <= cnt_nxt[FB-1:0];
          end
        end
        S_COMMIT: begin
          // renumber frames in use; the moved frame goes to the tail
          for (int g = 0; g < NF; g++) begin
            if (NB'(g) < n_q) begin
              if (FB'(g) == vic_q) begin
                rank_q[g] <= FB'(n_q - NB'(1));
              end else if (pos_q[g] > pos_q[vic_q]) begin
                rank_q[g] <= pos_q[g] - FB'(1);
              end else begin
                rank_q[g] <= pos_q[g];
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign res_valid_o   = res_valid_q;
  assign status_o      = res_q.status;
  assign frame_index_o = res_q.frame;
  assign io_op_o       = res_q.op;
  assign io_page_o     = res_q.page;
  assign last_o        = res_q.last;
  assign read_count_o  = reads_q;
  assign write_count_o = writes_q;

  `BPPR_ASSERT(a_wb_then_read,
    res_valid_o && !last_o |=> res_valid_o && last_o && io_op_o == bppr_pkg::IO_READ,
    "write-back word not followed by read word")
  `BPPR_ASSERT(a_busy_after_req,
    start && !busy && req_type_i != bppr_pkg::REQ_NONE |=> busy,
    "request accepted without going busy")
  `BPPR_ASSERT(a_err_no_io,
    res_valid_o && status_o != bppr_pkg::ST_OK |->
      io_op_o == bppr_pkg::IO_NONE && frame_index_o == '0,
    "error word carries io or frame")
  `BPPR_ASSERT_NEVER(a_write_in_use,
    mem_we && {1'b0, mem_waddr} >= n_q,
    "frame memory write outside frames in use")

endmodule
